### sv/bgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

   localparam int TICK_COUNTER_WIDTH = 16;

   localparam int CFG_WIDTH         = 16;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH    = 3;
   localparam int REQ_DATA_WIDTH    = 8;
   localparam int RSP_DATA_WIDTH    = 8;

   // register indexes, taken from paddr[2]
   localparam logic REG_LONG_PRESS   = 1'b0;
   localparam logic REG_DOUBLE_CLICK = 1'b1;

   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET   = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_RESET = 16'd400;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] long_press_ticks;
      logic [CFG_WIDTH-1:0] double_click_ticks;
   } cfg_type;

   // first field in the highest bit
   typedef struct packed {
      logic combo_hold;
      logic long_press;
      logic double_click;
      logic single_click;
   } event_type;

   localparam int EVENT_WIDTH = $bits(event_type);

endpackage

### sv/bgc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_csr
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module bgc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bgc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [bgc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [bgc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output bgc_pkg::cfg_type                     cfg
);

   bgc_pkg::cfg_type cfg_ff;
   bgc_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            bgc_pkg::REG_LONG_PRESS:
               cfg_in.long_press_ticks = csr_pwdata[bgc_pkg::CFG_WIDTH-1:0];
            bgc_pkg::REG_DOUBLE_CLICK:
               cfg_in.double_click_ticks = csr_pwdata[bgc_pkg::CFG_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= bgc_pkg::LONG_PRESS_RESET;
         cfg_ff.double_click_ticks <= bgc_pkg::DOUBLE_CLICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         bgc_pkg::REG_LONG_PRESS:
            csr_prdata[bgc_pkg::CFG_WIDTH-1:0] = cfg_ff.long_press_ticks;
         bgc_pkg::REG_DOUBLE_CLICK:
            csr_prdata[bgc_pkg::CFG_WIDTH-1:0] = cfg_ff.double_click_ticks;
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### sv/bgc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_core
// Gesture state registers and the per-tick next-state and event logic.
// ----------------------------------------------------------------------------
module bgc_core #(
   parameter int TICK_COUNTER_WIDTH = bgc_pkg::TICK_COUNTER_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bgc_pkg::cfg_type     cfg,
   input  logic                 tick_valid,
   input  logic                 button_level,
   input  logic                 manual_button_level,
   input  logic                 standby,
   output bgc_pkg::event_type   events
);

   localparam int W     = TICK_COUNTER_WIDTH;
   localparam int CMP_W = (W > bgc_pkg::CFG_WIDTH) ? W : bgc_pkg::CFG_WIDTH;
   localparam logic [W-1:0] CNT_MAX = '1;

   logic          prev_level_ff,   prev_level_in;
   logic [W-1:0]  press_ff,        press_in;
   logic          pending_ff,      pending_in;
   logic [W-1:0]  since_ff,        since_in;
   logic          combo_run_ff,    combo_run_in;
   logic [W-1:0]  combo_ff,        combo_in;
   logic          handled_ff,      handled_in;

   logic [W-1:0]     press_adv;
   logic [W-1:0]     since_adv;
   logic [W-1:0]     combo_adv;
   logic [CMP_W-1:0] long_thr;
   logic [CMP_W-1:0] dbl_thr;
   logic             hold;
   logic             press_edge;
   logic             release_edge;

   function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   assign long_thr     = CMP_W'(cfg.long_press_ticks);
   assign dbl_thr      = CMP_W'(cfg.double_click_ticks);
   assign hold         = !manual_button_level && !button_level && standby;
   assign press_edge   = prev_level_ff && !button_level;
   assign release_edge = !prev_level_ff && button_level;
   assign press_adv    = prev_level_ff ? press_ff : sat_inc(press_ff);
   assign since_adv    = pending_ff ? sat_inc(since_ff) : since_ff;
   // combo count restarts at zero on the first held tick
   assign combo_adv    = combo_run_ff ? sat_inc(combo_ff) : '0;

   always_comb begin
      events        = '0;
      prev_level_in = button_level;
      press_in      = press_adv;
      pending_in    = pending_ff;
      since_in      = since_adv;
      combo_run_in  = 1'b0;
      combo_in      = '0;
      handled_in    = handled_ff;

      if (hold) begin
         if (CMP_W'(combo_adv) >= long_thr) begin
            events.combo_hold = 1'b1;
            handled_in        = 1'b1;
         end else begin
            combo_run_in = 1'b1;
            combo_in     = combo_adv;
         end
      end

      if (press_edge) begin
         press_in   = '0;
         handled_in = 1'b0;
      end

      if (release_edge) begin
         priority if (CMP_W'(press_adv) >= long_thr) begin
            events.long_press = !handled_in;
         end else if (pending_ff && CMP_W'(since_adv) <= dbl_thr) begin
            events.double_click = 1'b1;
            pending_in          = 1'b0;
         end else begin
            pending_in = 1'b1;
            since_in   = '0;
         end
      end

      // window expiry
      if (pending_in && CMP_W'(since_in) > dbl_thr) begin
         events.single_click = 1'b1;
         pending_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b1;
         press_ff      <= '0;
         pending_ff    <= 1'b0;
         since_ff      <= '0;
         combo_run_ff  <= 1'b0;
         combo_ff      <= '0;
         handled_ff    <= 1'b0;
      end else if (tick_valid) begin
         prev_level_ff <= prev_level_in;
         press_ff      <= press_in;
         pending_ff    <= pending_in;
         since_ff      <= since_in;
         combo_run_ff  <= combo_run_in;
         combo_ff      <= combo_in;
         handled_ff    <= handled_in;
      end
   end

endmodule

### sv/button_gesture_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Single, double, long press and two-button combo detection per tick.
// ----------------------------------------------------------------------------
// One item per millisecond tick carries the sampled main and manual button
// levels and the standby flag; every item yields exactly one result item with
// four event flags. An item is taken every clock cycle while the result side
// keeps up: the gesture state updates in the cycle of acceptance and the flags
// land in a result register, and the next item is accepted while a result is
// still waiting as long as the result side takes it in the same cycle.
// Thresholds (long press and double-click window, in ticks) sit in two
// registers on the APB-style port at byte addresses 0 and 4.
module button_gesture_classifier #(
   parameter int TICK_COUNTER_WIDTH = bgc_pkg::TICK_COUNTER_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // bit 0 button_level, bit 1 manual_button_level, bit 2 standby
   input  logic [bgc_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // bit 0 single_click, bit 1 double_click, bit 2 long_press, bit 3 combo_hold
   output logic [bgc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bgc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [bgc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [bgc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   bgc_pkg::cfg_type   cfg;
   bgc_pkg::event_type events;
   bgc_pkg::event_type result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   bgc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bgc_core #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .tick_valid          (accept),
      .button_level        (req_tdata[0]),
      .manual_button_level (req_tdata[1]),
      .standby             (req_tdata[2]),
      .events              (events)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         result_in    = events;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(bgc_pkg::RSP_DATA_WIDTH - bgc_pkg::EVENT_WIDTH)'(0), result_ff};

endmodule

### sv/bgc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_checker
// Port-level checks of the button gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bgc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic [bgc_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [bgc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   // no result may appear right out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an accepted item always leaves a result behind
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // an empty result register never blocks the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // combo needs a held button, long and double need a release; single excludes double
   a_event_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && (rsp_tdata[2] || rsp_tdata[1]))
                     && !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("conflicting gesture events in one item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button gesture classifier.
// ----------------------------------------------------------------------------
// Tick items go in on the req stream. A gesture scoreboard predicts the four
// event flags of every accepted tick and checks each rsp item in order. Both
// thresholds are reprogrammed between phases, including zero for both and
// all-ones for the double-click window. Random gestures are mostly well-formed
// press/release sequences with random noise mixed in.
// ----------------------------------------------------------------------------
module tb;

   localparam int  CYCLE_LIMIT = 100000;
   localparam logic PRESSED    = 1'b0;
   localparam logic RELEASED   = 1'b1;
   localparam int  CHUNK_ITEMS = 130;

   class gesture_scoreboard;
      logic [bgc_pkg::CFG_WIDTH-1:0]          long_cfg;
      logic [bgc_pkg::CFG_WIDTH-1:0]          dbl_cfg;
      logic                                   prev_level;
      logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] press_cnt;
      logic                                   click_pend;
      logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] since_click_cnt;
      logic                                   combo_run;
      logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] combo_cnt;
      logic                                   long_done;
      bgc_pkg::event_type                     expected_events[$];
      int                                     mismatches;

      function new();
         long_cfg        = bgc_pkg::LONG_PRESS_RESET;
         dbl_cfg         = bgc_pkg::DOUBLE_CLICK_RESET;
         prev_level      = RELEASED;
         press_cnt       = '0;
         click_pend      = 1'b0;
         since_click_cnt = '0;
         combo_run       = 1'b0;
         combo_cnt       = '0;
         long_done       = 1'b0;
         mismatches      = 0;
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         mismatches++;
      endtask

      function void set_reg(logic idx, logic [bgc_pkg::CFG_WIDTH-1:0] value);
         if (idx == bgc_pkg::REG_LONG_PRESS) long_cfg = value;
         else dbl_cfg = value;
      endfunction

      function logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] bump(
         logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      // one tick in, one set of event flags predicted
      function void note_item(logic [2:0] fields);
         logic               level;
         logic               manual;
         logic               stby;
         bgc_pkg::event_type ev;
         level  = fields[0];
         manual = fields[1];
         stby   = fields[2];
         ev     = '0;
         if (prev_level == PRESSED) press_cnt = bump(press_cnt);
         if (click_pend) since_click_cnt = bump(since_click_cnt);
         if (manual == PRESSED && level == PRESSED && stby) begin
            if (!combo_run) begin
               combo_run = 1'b1;
               combo_cnt = '0;
            end else begin
               combo_cnt = bump(combo_cnt);
            end
            if (combo_cnt >= long_cfg) begin
               ev.combo_hold = 1'b1;
               long_done     = 1'b1;
               combo_run     = 1'b0;
               combo_cnt     = '0;
            end
         end else begin
            combo_run = 1'b0;
            combo_cnt = '0;
         end
         if (prev_level == RELEASED && level == PRESSED) begin
            press_cnt = '0;
            long_done = 1'b0;
         end
         if (prev_level == PRESSED && level == RELEASED) begin
            if (press_cnt >= long_cfg) begin
               if (!long_done) ev.long_press = 1'b1;
            end else if (click_pend && since_click_cnt <= dbl_cfg) begin
               ev.double_click = 1'b1;
               click_pend      = 1'b0;
            end else begin
               click_pend      = 1'b1;
               since_click_cnt = '0;
            end
         end
         if (click_pend && since_click_cnt > dbl_cfg) begin
            ev.single_click = 1'b1;
            click_pend      = 1'b0;
         end
         prev_level = level;
         expected_events.push_back(ev);
      endfunction

      task compare_flag(string name, logic got, logic want);
         if (got !== want) report($sformatf("%s is %b, expected %b", name, got, want));
      endtask

      task check_result(logic [bgc_pkg::RSP_DATA_WIDTH-1:0] data);
         bgc_pkg::event_type got;
         bgc_pkg::event_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("result item 0x%02h with no expectation", data));
            return;
         end
         want = expected_events.pop_front();
         got  = data[bgc_pkg::EVENT_WIDTH-1:0];
         compare_flag("single_click", got.single_click, want.single_click);
         compare_flag("double_click", got.double_click, want.double_click);
         compare_flag("long_press", got.long_press, want.long_press);
         compare_flag("combo_hold", got.combo_hold, want.combo_hold);
         if (data[bgc_pkg::RSP_DATA_WIDTH-1:bgc_pkg::EVENT_WIDTH] !== '0)
            report($sformatf("padding bits not zero in 0x%02h", data));
      endtask
   endclass

   logic                               clock;
   logic                               reset;
   logic [bgc_pkg::REQ_DATA_WIDTH-1:0] req_tdata;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [bgc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [bgc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [bgc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [bgc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   gesture_scoreboard sb;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                cycle_count;

   button_gesture_classifier u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stalls, check on every handshake
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   task send_item(logic [2:0] fields);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= bgc_pkg::REQ_DATA_WIDTH'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      // upper bits are don't-care for the block
      req_tdata  <= {(bgc_pkg::REQ_DATA_WIDTH-3)'($urandom), fields};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(fields);
   endtask

   task hold(logic level, logic manual, logic stby, int n);
      repeat (n) send_item({stby, manual, level});
   endtask

   task quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write, then read back
   task csr_write(logic idx, logic [bgc_pkg::CFG_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[bgc_pkg::CFG_WIDTH-1:0] !== value)
         sb.report($sformatf("register %0d reads 0x%04h, expected 0x%04h",
                             idx, csr_prdata[bgc_pkg::CFG_WIDTH-1:0], value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task set_thresholds(logic [bgc_pkg::CFG_WIDTH-1:0] long_ticks,
                       logic [bgc_pkg::CFG_WIDTH-1:0] dbl_ticks);
      quiesce();
      csr_write(bgc_pkg::REG_LONG_PRESS, long_ticks);
      csr_write(bgc_pkg::REG_DOUBLE_CLICK, dbl_ticks);
   endtask

   // mostly press/release gestures sized around the thresholds, some noise
   task random_gestures(int budget);
      int   sent;
      int   press_len;
      int   gap_len;
      int   lim_press;
      int   lim_gap;
      logic combo;
      logic stby;
      logic manual;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 20) begin
            press_len = $urandom_range(1, 6);
            repeat (press_len) send_item(3'($urandom));
            sent += press_len;
         end else begin
            combo     = ($urandom_range(3) == 0);
            stby      = combo ? 1'b1 : 1'($urandom);
            manual    = combo ? PRESSED : (($urandom_range(4) == 0) ? PRESSED : RELEASED);
            lim_press = 2 * int'(sb.long_cfg) + 3;
            lim_gap   = int'(sb.dbl_cfg) + 3;
            if (lim_press > 60) lim_press = 60;
            if (lim_gap > 60) lim_gap = 60;
            press_len = $urandom_range(1, lim_press);
            gap_len   = $urandom_range(1, lim_gap);
            hold(PRESSED, manual, stby, press_len);
            hold(RELEASED, 1'($urandom), 1'($urandom), gap_len);
            sent += press_len + gap_len;
         end
      end
   endtask

   initial begin
      sb            = new();
      send_idle_pct = 35;
      recv_idle_pct = 72;
      reset         = 1'b1;
      req_tdata     = '0;
      req_tvalid    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset thresholds: double, then single after the window runs out
      hold(RELEASED, RELEASED, 1'b0, 2);
      hold(PRESSED, RELEASED, 1'b0, 3);
      hold(RELEASED, RELEASED, 1'b0, 5);
      hold(PRESSED, RELEASED, 1'b1, 2);
      hold(RELEASED, RELEASED, 1'b1, 1);
      hold(PRESSED, PRESSED, 1'b0, 1);
      hold(RELEASED, PRESSED, 1'b0, 402);

      // zero thresholds
      set_thresholds('0, '0);
      hold(PRESSED, RELEASED, 1'b0, 1);
      hold(RELEASED, RELEASED, 1'b0, 1);
      hold(PRESSED, PRESSED, 1'b1, 3);
      hold(RELEASED, RELEASED, 1'b1, 2);
      set_thresholds(16'd5, '0);
      hold(PRESSED, RELEASED, 1'b0, 2);
      hold(RELEASED, RELEASED, 1'b0, 3);

      // combo repeats while held, then the long release is swallowed
      set_thresholds(16'd3, 16'd2);
      hold(PRESSED, PRESSED, 1'b1, 10);
      hold(RELEASED, PRESSED, 1'b1, 1);
      hold(RELEASED, RELEASED, 1'b0, 4);

      set_thresholds(16'd1, 16'd1);
      random_gestures(CHUNK_ITEMS);
      set_thresholds(16'($urandom_range(2, 16)), 16'($urandom_range(1, 12)));
      random_gestures(CHUNK_ITEMS);

      quiesce();
      send_idle_pct = 72;
      recv_idle_pct = 35;
      set_thresholds(16'($urandom_range(2, 16)), 16'($urandom_range(1, 12)));
      random_gestures(CHUNK_ITEMS);
      set_thresholds(16'd6, 16'hffff);
      random_gestures(CHUNK_ITEMS);

      quiesce();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_thresholds(16'($urandom_range(2, 16)), 16'($urandom_range(1, 12)));
      random_gestures(CHUNK_ITEMS);
      set_thresholds(16'($urandom_range(1, 8)), 16'($urandom_range(1, 20)));
      random_gestures(CHUNK_ITEMS);

      quiesce();
      repeat (8) @(posedge clock);
      if (sb.expected_events.size() != 0)
         sb.report($sformatf("%0d expected items never arrived", sb.expected_events.size()));
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
